FILE: src/satlb_pkg.sv
package satlb_pkg;

    // fixed field widths
    localparam int VADDR_PORT_W = 48;
    localparam int FRAME_W      = 36;
    localparam int RANK_OUT_W   = 3;

    // defaults for the top-level parameters
    localparam int DEF_PAGE_OFFSET_BITS = 12;
    localparam int DEF_NUM_SETS         = 16;
    localparam int DEF_NUM_WAYS         = 4;
    localparam int DEF_VADDR_BITS       = 48;

    // request action codes; the remaining code is a no-op
    localparam logic [1:0] ACT_XLATE = 2'd0;
    localparam logic [1:0] ACT_PEEK  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    typedef struct packed {
        logic hit;
        logic fault;
        logic wr_en;
    } t_set_stat;

endpackage

FILE: src/satlb_ram.sv
module satlb_ram
    import satlb_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/satlb_set_upd.sv
module satlb_set_upd
    import satlb_pkg::*;
#(
    parameter int NUM_WAYS = DEF_NUM_WAYS,
    parameter int TAG_W    = 32,
    parameter int RANK_W   = 3
) (
    input  logic [1:0]                         i_action,
    input  logic [TAG_W-1:0]                   i_tag,
    input  logic [FRAME_W-1:0]                 i_walk_frame,
    input  logic                               i_walk_fault,
    input  logic [NUM_WAYS-1:0]                i_valid,
    input  logic [NUM_WAYS-1:0][TAG_W-1:0]     i_tags,
    input  logic [NUM_WAYS-1:0][FRAME_W-1:0]   i_frames,
    input  logic [NUM_WAYS-1:0][RANK_W-1:0]    i_ranks,
    output logic [NUM_WAYS-1:0]                o_valid,
    output logic [NUM_WAYS-1:0][TAG_W-1:0]     o_tags,
    output logic [NUM_WAYS-1:0][FRAME_W-1:0]   o_frames,
    output logic [NUM_WAYS-1:0][RANK_W-1:0]    o_ranks,
    output logic [FRAME_W-1:0]                 o_frame,
    output logic [RANK_W-1:0]                  o_rank,
    output t_set_stat                          o_stat
);

    localparam int WAY_W = $clog2(NUM_WAYS);
    localparam logic [RANK_W-1:0] RANK_MRU = RANK_W'(1);
    localparam logic [RANK_W-1:0] RANK_LRU = RANK_W'(NUM_WAYS);

    logic [NUM_WAYS-1:0] match;
    logic                hit;
    logic                any_inv;
    logic                any_lru;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    inv_way;
    logic [WAY_W-1:0]    lru_way;
    logic [WAY_W-1:0]    tgt;
    logic [RANK_W-1:0]   old_rank;
    logic                xlate;
    logic                wr;

    always_comb begin
        hit_way = '0;
        inv_way = '0;
        lru_way = '0;
        any_inv = 1'b0;
        any_lru = 1'b0;
        // descending so the lowest matching way wins
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            match[w] = i_valid[w] && (i_tags[w] == i_tag);
            if (match[w]) begin
                hit_way = WAY_W'(w);
            end
            if (!i_valid[w]) begin
                inv_way = WAY_W'(w);
                any_inv = 1'b1;
            end
            if (i_ranks[w] == RANK_LRU) begin
                lru_way = WAY_W'(w);
                any_lru = 1'b1;
            end
        end
        hit = |match;

        // target: the hit way on a hit; on a fill, first empty way, else the least recent, else way 0
        if (hit) begin
            tgt = hit_way;
        end else if (any_inv) begin
            tgt = inv_way;
        end else if (any_lru) begin
            tgt = lru_way;
        end else begin
            tgt = '0;
        end

        xlate    = (i_action == ACT_XLATE);
        wr       = xlate && (hit || !i_walk_fault);
        old_rank = i_ranks[tgt];
        o_frame  = hit ? i_frames[hit_way] : i_walk_frame;
        o_rank   = hit ? i_ranks[hit_way] : '0;

        o_valid  = i_valid;
        o_tags   = i_tags;
        o_frames = i_frames;
        o_ranks  = i_ranks;
        if (wr) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                if (WAY_W'(w) != tgt && i_valid[w] &&
                    (old_rank == '0 || i_ranks[w] < old_rank)) begin
                    o_ranks[w] = i_ranks[w] + RANK_W'(1);
                end
            end
            o_valid[tgt]  = 1'b1;
            o_tags[tgt]   = i_tag;
            o_frames[tgt] = o_frame;
            o_ranks[tgt]  = RANK_MRU;
        end

        o_stat.hit   = hit && (xlate || i_action == ACT_PEEK);
        o_stat.fault = xlate && !hit && i_walk_fault;
        o_stat.wr_en = wr;
    end

endmodule

FILE: src/set_assoc_tlb_lru.sv
// Channel   Dir  Handshake               Payload
// request   in   i_in_valid/o_in_ready   i_action, i_virt_addr, i_walk_frame, i_walk_fault
// result    out  o_out_valid/i_out_ready o_phys_addr, o_fault, o_hit, o_lru_rank
//
// One request per cycle unless the result stalls; each taken request goes through the lookup stage
// (set RAM read at the accepting edge), then lookup/LRU update into the result register.
// The set row is read-modify-written; a write-to-read bypass covers back-to-back
// requests to the same set. NUM_SETS must be a power of two.
// Reset and clear drop all per-set live flags at once, so no sweep is needed.
// A stalled result holds the lookup stage; requests are taken while it is free or advancing.
module set_assoc_tlb_lru
    import satlb_pkg::*;
#(
    parameter int PAGE_OFFSET_BITS = DEF_PAGE_OFFSET_BITS,
    parameter int NUM_SETS         = DEF_NUM_SETS,
    parameter int NUM_WAYS         = DEF_NUM_WAYS,
    parameter int VADDR_BITS       = DEF_VADDR_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [1:0]              i_action,
    input  logic [VADDR_PORT_W-1:0] i_virt_addr,
    input  logic [FRAME_W-1:0]      i_walk_frame,
    input  logic                    i_walk_fault,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [VADDR_PORT_W-1:0] o_phys_addr,
    output logic                    o_fault,
    output logic                    o_hit,
    output logic [RANK_OUT_W-1:0]   o_lru_rank
);

    localparam int VA_W    = (VADDR_BITS < VADDR_PORT_W) ? VADDR_BITS : VADDR_PORT_W;
    localparam int SET_W   = $clog2(NUM_SETS);
    localparam int TAG_RAW = VA_W - PAGE_OFFSET_BITS - SET_W;
    localparam int TAG_W   = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int RANK_W  = $clog2(NUM_WAYS + 1);
    localparam int ROW_W   = NUM_WAYS * (1 + TAG_W + FRAME_W + RANK_W);
    localparam logic [VADDR_PORT_W-1:0] VA_MASK =
        (VA_W >= VADDR_PORT_W) ? '1 : ((VADDR_PORT_W'(1) << VA_W) - VADDR_PORT_W'(1));

    // input side
    logic [VADDR_PORT_W-1:0] va_m;
    logic [SET_W-1:0]        in_set;
    logic                    in_acc;
    logic                    s1_adv;

    // lookup stage
    logic                        r_s1_valid;
    logic [1:0]                  r_s1_action;
    logic [SET_W-1:0]            r_s1_set;
    logic [TAG_W-1:0]            r_s1_tag;
    logic [PAGE_OFFSET_BITS-1:0] r_s1_off;
    logic [FRAME_W-1:0]          r_s1_wframe;
    logic                        r_s1_wfault;

    logic [NUM_SETS-1:0] r_live;
    logic                r_byp_valid;
    logic [ROW_W-1:0]    r_byp_row;
    logic [ROW_W-1:0]    ram_row;
    logic [ROW_W-1:0]    cur_row;
    logic [ROW_W-1:0]    new_row;

    logic [NUM_WAYS-1:0]              cur_valid, new_valid;
    logic [NUM_WAYS-1:0][TAG_W-1:0]   cur_tags, new_tags;
    logic [NUM_WAYS-1:0][FRAME_W-1:0] cur_frames, new_frames;
    logic [NUM_WAYS-1:0][RANK_W-1:0]  cur_ranks, new_ranks;
    logic [FRAME_W-1:0]               use_frame;
    logic [RANK_W-1:0]                use_rank;
    t_set_stat                        stat;
    logic                             wr_en;

    logic [VADDR_PORT_W-1:0] n_phys;

    // result register
    logic                    r_out_valid;
    logic [VADDR_PORT_W-1:0] r_out_phys;
    logic                    r_out_fault;
    logic                    r_out_hit;
    logic [RANK_OUT_W-1:0]   r_out_rank;

    assign va_m   = i_virt_addr & VA_MASK;
    assign in_set = SET_W'(va_m >> PAGE_OFFSET_BITS);

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;
    assign wr_en      = s1_adv && stat.wr_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_action <= i_action;
            r_s1_set    <= in_set;
            r_s1_tag    <= TAG_W'(va_m >> (PAGE_OFFSET_BITS + SET_W));
            r_s1_off    <= i_virt_addr[PAGE_OFFSET_BITS-1:0];
            r_s1_wframe <= i_walk_frame;
            r_s1_wfault <= i_walk_fault;
            r_byp_row   <= new_row;
        end
    end

    // the RAM read at this edge misses a write landing on the same set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_valid <= 1'b0;
        end else if (in_acc) begin
            r_byp_valid <= wr_en && (r_s1_set == in_set);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= '0;
        end else if (s1_adv && r_s1_action == ACT_CLEAR) begin
            r_live <= '0;
        end else if (wr_en) begin
            r_live[r_s1_set] <= 1'b1;
        end
    end

    satlb_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_set),
        .i_wr_data (new_row),
        .i_rd_en   (in_acc),
        .i_rd_addr (in_set),
        .o_rd_data (ram_row)
    );

    // a set not written since clear reads as empty
    always_comb begin
        if (!r_live[r_s1_set]) begin
            cur_row = '0;
        end else if (r_byp_valid) begin
            cur_row = r_byp_row;
        end else begin
            cur_row = ram_row;
        end
    end

    assign {cur_valid, cur_tags, cur_frames, cur_ranks} = cur_row;
    assign new_row = {new_valid, new_tags, new_frames, new_ranks};

    satlb_set_upd #(
        .NUM_WAYS (NUM_WAYS),
        .TAG_W    (TAG_W),
        .RANK_W   (RANK_W)
    ) u_set_upd (
        .i_action     (r_s1_action),
        .i_tag        (r_s1_tag),
        .i_walk_frame (r_s1_wframe),
        .i_walk_fault (r_s1_wfault),
        .i_valid      (cur_valid),
        .i_tags       (cur_tags),
        .i_frames     (cur_frames),
        .i_ranks      (cur_ranks),
        .o_valid      (new_valid),
        .o_tags       (new_tags),
        .o_frames     (new_frames),
        .o_ranks      (new_ranks),
        .o_frame      (use_frame),
        .o_rank       (use_rank),
        .o_stat       (stat)
    );

    always_comb begin
        if (stat.wr_en) begin
            n_phys = (VADDR_PORT_W'(use_frame) << PAGE_OFFSET_BITS)
                   | VADDR_PORT_W'(r_s1_off);
        end else begin
            n_phys = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_phys  <= n_phys;
            r_out_fault <= stat.fault;
            r_out_hit   <= stat.hit;
            r_out_rank  <= (r_s1_action == ACT_PEEK) ? RANK_OUT_W'(use_rank) : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_phys_addr = r_out_phys;
    assign o_fault     = r_out_fault;
    assign o_hit       = r_out_hit;
    assign o_lru_rank  = r_out_rank;

endmodule
